// ----- rtl/ilir_pkg.sv -----
package ilir_pkg;

  // widths of the request and result fields
  localparam int unsigned OpBits    = 3;
  localparam int unsigned IndexBits = 7;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned StatBits  = 2;

  // operation codes
  typedef enum logic [OpBits-1:0] {
    OP_INSERT    = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_REM_SLICE = 3'd2,
    OP_READ      = 3'd3,
    OP_WRITE     = 3'd4,
    OP_SET_LEN   = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [StatBits-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_TAIL  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [OpBits-1:0]    op;
    logic [IndexBits-1:0] index;
    logic [IndexBits-1:0] end_index;
    logic [DataBits-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [DataBits-1:0]  read_data;
    logic [IndexBits-1:0] count;
    logic [StatBits-1:0]  status;
  } res_t;

endpackage

// ----- rtl/indexed_list_insert_remove.sv -----
// Ordered list of up to CAPACITY words held in one memory with a write port and a
// registered read port, plus a live count. Each request returns one result with
// read data, the count after the request and a status; a failed request changes
// nothing. Read, write, set length, failed requests, and insert or remove that move
// no entries need no shift. Insert moves N = count - index entries up, starting
// from the top, and then places the new word; remove or remove slice moves
// N = count - end entries down. The memory moves one entry per cycle. One request
// is in work at a time; a finished result waits in the output register while the
// next request is taken. After reset the block stalls requests while it clears
// the store.
module indexed_list_insert_remove #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ilir_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ilir_pkg::res_t out_res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic                 res_valid, res_ready;
  ilir_pkg::res_t       res;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
  logic                 out_valid_q;
  ilir_pkg::res_t       out_q;

  ilir_seq #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ilir_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register, free when empty or being taken
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ----- rtl/ilir_ram.sv -----
module ilir_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ilir_seq.sv -----
module ilir_seq #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned WORD_BITS = 32,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  ilir_pkg::req_t       in_req_i,
  output logic                 in_stall_o,
  input  logic                 res_ready_i,
  output logic                 res_valid_o,
  output ilir_pkg::res_t       res_o,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_waddr_o,
  output logic [WORD_BITS-1:0] mem_wdata_o,
  output logic                 mem_re_o,
  output logic [AW-1:0]        mem_raddr_o,
  input  logic [WORD_BITS-1:0] mem_rdata_i
);

  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned XW  = (CW > ilir_pkg::IndexBits) ? CW : ilir_pkg::IndexBits;
  localparam int unsigned VW  = (WORD_BITS > ilir_pkg::DataBits) ? WORD_BITS
                                                                 : ilir_pkg::DataBits;
  localparam logic [XW-1:0] CapX  = XW'(CAPACITY);
  localparam logic [AW-1:0] LastA = AW'(CAPACITY - 1);

  ilir_pkg::state_e state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        rp_q, rp_d;
  logic [AW-1:0]        wp_q, wp_d;
  logic [XW-1:0]        left_q, left_d;
  logic                 down_q, down_d;
  logic                 tail_q, tail_d;
  logic                 rd_q, rd_d;
  ilir_pkg::status_e    status_q, status_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [WORD_BITS-1:0] val_q, val_d;

  logic                 accept;
  logic [XW-1:0]        idx_x, end_x, cnt_x;
  logic [XW-1:0]        new_cnt, moves, src;
  ilir_pkg::status_e    chk_status;
  logic                 chg_cnt;
  logic [VW-1:0]        val_ext, rd_ext;

  assign accept  = in_valid_i && (state_q == ilir_pkg::S_IDLE);
  assign idx_x   = XW'(in_req_i.index);
  assign end_x   = XW'(in_req_i.end_index);
  assign cnt_x   = XW'(count_q);
  assign val_ext = VW'(in_req_i.value);
  assign rd_ext  = VW'(mem_rdata_i);

  // request decode: range checks, new count and shift extent
  always_comb begin
    chk_status = ilir_pkg::ST_OK;
    chg_cnt    = 1'b0;
    new_cnt    = cnt_x;
    moves      = '0;
    src        = end_x;
    case (in_req_i.op)
      ilir_pkg::OP_INSERT: begin
        if (idx_x > cnt_x) begin
          chk_status = ilir_pkg::ST_RANGE;
        end else if (cnt_x >= CapX) begin
          chk_status = ilir_pkg::ST_FULL;
        end else begin
          chg_cnt = 1'b1;
          new_cnt = cnt_x + XW'(1);
          moves   = cnt_x - idx_x;
        end
      end
      ilir_pkg::OP_REMOVE: begin
        if (idx_x >= cnt_x) begin
          chk_status = ilir_pkg::ST_RANGE;
        end else begin
          chg_cnt = 1'b1;
          new_cnt = cnt_x - XW'(1);
          moves   = cnt_x - idx_x - XW'(1);
          src     = idx_x + XW'(1);
        end
      end
      ilir_pkg::OP_REM_SLICE: begin
        if (idx_x >= cnt_x || end_x > cnt_x || end_x <= idx_x) begin
          chk_status = ilir_pkg::ST_RANGE;
        end else begin
          chg_cnt = 1'b1;
          new_cnt = cnt_x - (end_x - idx_x);
          moves   = cnt_x - end_x;
        end
      end
      ilir_pkg::OP_READ, ilir_pkg::OP_WRITE: begin
        if (idx_x >= cnt_x) begin
          chk_status = ilir_pkg::ST_RANGE;
        end
      end
      ilir_pkg::OP_SET_LEN: begin
        if (idx_x > CapX) begin
          chk_status = ilir_pkg::ST_FULL;
        end else begin
          chg_cnt = 1'b1;
          new_cnt = idx_x;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    left_d      = left_q;
    down_d      = down_q;
    tail_d      = tail_q;
    rd_d        = rd_q;
    status_d    = status_q;
    idx_d       = idx_q;
    val_d       = val_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wp_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = rp_q;
    res_valid_o = 1'b0;
    case (state_q)
      ilir_pkg::S_CLEAR: begin
        // zero the store after reset, one entry per cycle
        mem_we_o    = 1'b1;
        mem_waddr_o = rp_q;
        mem_wdata_o = '0;
        rp_d        = rp_q + AW'(1);
        if (rp_q == LastA) begin
          state_d = ilir_pkg::S_IDLE;
        end
      end
      ilir_pkg::S_IDLE: begin
        if (accept) begin
          status_d = chk_status;
          idx_d    = idx_x[AW-1:0];
          val_d    = val_ext[WORD_BITS-1:0];
          rd_d     = 1'b0;
          tail_d   = 1'b0;
          state_d  = ilir_pkg::S_RESP;
          if (chg_cnt) begin
            count_d = new_cnt[CW-1:0];
          end
          if (chk_status == ilir_pkg::ST_OK) begin
            case (in_req_i.op)
              ilir_pkg::OP_READ: begin
                mem_re_o    = 1'b1;
                mem_raddr_o = idx_x[AW-1:0];
                rd_d        = 1'b1;
              end
              ilir_pkg::OP_WRITE: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = idx_x[AW-1:0];
                mem_wdata_o = val_ext[WORD_BITS-1:0];
              end
              ilir_pkg::OP_INSERT: begin
                if (moves == '0) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = idx_x[AW-1:0];
                  mem_wdata_o = val_ext[WORD_BITS-1:0];
                end else begin
                  // move entries up, starting from the top
                  mem_re_o    = 1'b1;
                  mem_raddr_o = AW'(cnt_x - XW'(1));
                  rp_d        = AW'(cnt_x - XW'(2));
                  wp_d        = AW'(cnt_x);
                  left_d      = moves;
                  down_d      = 1'b1;
                  tail_d      = 1'b1;
                  state_d     = ilir_pkg::S_SHIFT;
                end
              end
              ilir_pkg::OP_REMOVE, ilir_pkg::OP_REM_SLICE: begin
                if (moves != '0) begin
                  // move entries down over the gap, starting from the bottom
                  mem_re_o    = 1'b1;
                  mem_raddr_o = src[AW-1:0];
                  rp_d        = AW'(src + XW'(1));
                  wp_d        = idx_x[AW-1:0];
                  left_d      = moves;
                  down_d      = 1'b0;
                  state_d     = ilir_pkg::S_SHIFT;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ilir_pkg::S_SHIFT: begin
        // write the word read last cycle, read the next one
        mem_we_o = 1'b1;
        wp_d     = down_q ? (wp_q - AW'(1)) : (wp_q + AW'(1));
        left_d   = left_q - XW'(1);
        if (left_q != XW'(1)) begin
          mem_re_o = 1'b1;
          rp_d     = down_q ? (rp_q - AW'(1)) : (rp_q + AW'(1));
        end else begin
          state_d = tail_q ? ilir_pkg::S_TAIL : ilir_pkg::S_RESP;
        end
      end
      ilir_pkg::S_TAIL: begin
        // place the inserted word
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = val_q;
        state_d     = ilir_pkg::S_RESP;
      end
      ilir_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ilir_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ilir_pkg::S_IDLE;
      end
    endcase
  end

  // result fields
  always_comb begin
    res_o.read_data = rd_q ? rd_ext[ilir_pkg::DataBits-1:0] : '0;
    res_o.count     = cnt_x[ilir_pkg::IndexBits-1:0];
    res_o.status    = status_q;
  end

  assign in_stall_o = (state_q != ilir_pkg::S_IDLE);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ilir_pkg::S_CLEAR;
      count_q  <= '0;
      rp_q     <= '0;
      wp_q     <= '0;
      left_q   <= '0;
      down_q   <= 1'b0;
      tail_q   <= 1'b0;
      rd_q     <= 1'b0;
      status_q <= ilir_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rp_q     <= rp_d;
      wp_q     <= wp_d;
      left_q   <= left_d;
      down_q   <= down_d;
      tail_q   <= tail_d;
      rd_q     <= rd_d;
      status_q <= status_d;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
  end

endmodule
